// File: rtl/nat_pkg.sv
package nat_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MAX_RUN     = 64;
  localparam int RUN_W       = $clog2(MAX_RUN + 1);

  localparam logic [1:0] OP_LOAD      = 2'd0;
  localparam logic [1:0] OP_CLOSEST   = 2'd1;
  localparam logic [1:0] OP_INTERSECT = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  localparam logic CFG_ENTRY_COUNT  = 1'b0;
  localparam logic CFG_BEAM_SPACING = 1'b1;

  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [15:0] HALF_TURN = 16'd18000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [8:0]  slot;
    logic [15:0] entry_angle;
    logic [15:0] entry_azimuth;
    logic [9:0]  entry_beam;
    logic [15:0] query_azimuth;
    logic [15:0] query_width;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  beam_index;
    logic [15:0] beam_azimuth;
    logic        last;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] azimuth;
    logic [9:0]  beam;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    entry_t            wdata;
  } mem_req_t;

  // Circular distance in centidegrees between two angles below 65536.
  function automatic logic [15:0] circ_dist(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    logic [15:0] r;
    logic [15:0] m;
    d = (a >= b) ? (a - b) : (b - a);
    r = (d >= FULL_TURN) ? (d - FULL_TURN) : d;
    m = (r >= HALF_TURN) ? (r - HALF_TURN) : (HALF_TURN - r);
    return HALF_TURN - m;
  endfunction

endpackage

// File: rtl/nat_ram.sv
module nat_ram (
  input  logic              clk_i,
  input  nat_pkg::mem_req_t req_i,
  output nat_pkg::entry_t   rdata_o
);

  nat_pkg::entry_t mem [nat_pkg::TABLE_DEPTH];
  nat_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/nat_seq.sv
module nat_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  nat_pkg::in_item_t         in_item_i,
  input  logic [nat_pkg::CNT_W-1:0] used_count_i,
  input  logic [15:0]               beam_spacing_i,
  output nat_pkg::mem_req_t         mem_req_o,
  input  nat_pkg::entry_t           mem_rdata_i,
  input  logic                      out_free_i,
  output logic                      res_push_o,
  output nat_pkg::out_item_t        res_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_NORM      = 4'd1;
  localparam logic [3:0] S_SRCH      = 4'd2;
  localparam logic [3:0] S_CMP       = 4'd3;
  localparam logic [3:0] S_NEAR_A    = 4'd4;
  localparam logic [3:0] S_NEAR_B    = 4'd5;
  localparam logic [3:0] S_NEAR_L    = 4'd6;
  localparam logic [3:0] S_PICK      = 4'd7;
  localparam logic [3:0] S_EMIT_RD   = 4'd8;
  localparam logic [3:0] S_EMIT_PUT  = 4'd9;
  localparam logic [3:0] S_ERR       = 4'd10;

  localparam logic [1:0] SEL_NEAR  = 2'd0;
  localparam logic [1:0] SEL_BEGIN = 2'd1;
  localparam logic [1:0] SEL_END   = 2'd2;

  localparam int AW = nat_pkg::ADDR_W;
  localparam int CW = nat_pkg::CNT_W;
  localparam int RW = nat_pkg::RUN_W;
  localparam logic signed [19:0] TURN2 = 20'sd72000;

  logic [3:0]          state_q, state_d;
  logic [1:0]          sel_q, sel_d;
  logic [CW-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, begin_q, begin_d;
  logic [16:0]         t_q, t_d, hwf_q, hwf_d;
  logic signed [19:0]  lw_q, lw_d, hw_q, hw_d;
  logic                wrap_q, wrap_d, trunc_q, trunc_d;
  logic [AW-1:0]       a_q, a_d, b_q, b_d, cur_q, cur_d;
  logic [RW-1:0]       left_q, left_d;
  logic [1:0]          err_q, err_d;
  logic [15:0]         qaz_q, qaz_d;
  nat_pkg::entry_t     ent_a_q, ent_a_d, ent_b_q, ent_b_d;

  logic [CW-1:0]       mid_c, n_m1, nxt;
  logic [17:0]         reach;
  logic [CW:0]         cnt;
  logic [15:0]         dist_a, dist_b;
  logic                lw_ok, hw_ok;
  logic [16:0]         lw_p1, hw_p1;

  assign in_stall_o = (state_q != S_IDLE);
  assign mid_c  = lo_q + ((hi_q - lo_q) >> 1);
  assign n_m1   = used_count_i - CW'(1);
  assign nxt    = {1'b0, cur_q} + CW'(1);
  assign reach  = {2'b0, in_item_i.query_width} + {1'b0, beam_spacing_i, 1'b0};
  // The query angle is held from acceptance; the input may already carry the next item.
  assign dist_a = nat_pkg::circ_dist(ent_a_q.angle, qaz_q);
  assign dist_b = nat_pkg::circ_dist(ent_b_q.angle, qaz_q);
  assign lw_ok  = (lw_q >= 20'sd0) && (lw_q < TURN2);
  assign hw_ok  = (hw_q >= 20'sd0) && (hw_q < TURN2);
  assign lw_p1  = lw_q[16:0] + 17'd1;
  assign hw_p1  = hw_q[16:0] + 17'd1;

  always_comb begin
    if (wrap_q) begin
      cnt = {1'b0, used_count_i} - {1'b0, begin_q} + {1'b0, lo_q};
    end else if (lo_q > begin_q) begin
      cnt = {1'b0, lo_q} - {1'b0, begin_q};
    end else begin
      cnt = '0;
    end
  end

  always_comb begin
    state_d = state_q;  sel_d = sel_q;  lo_d = lo_q;  hi_d = hi_q;  mid_d = mid_q;
    begin_d = begin_q;  t_d = t_q;  hwf_d = hwf_q;  lw_d = lw_q;  hw_d = hw_q;
    wrap_d = wrap_q;  trunc_d = trunc_q;  a_d = a_q;  b_d = b_q;  cur_d = cur_q;
    left_d = left_q;  err_d = err_q;  ent_a_d = ent_a_q;  ent_b_d = ent_b_q;
    qaz_d = qaz_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.addr  = cur_q;
    mem_req_o.wdata = {in_item_i.entry_angle, in_item_i.entry_azimuth, in_item_i.entry_beam};
    res_push_o = 1'b0;
    res_o      = '0;

    case (state_q)
      S_IDLE: begin
        mem_req_o.addr = in_item_i.slot[AW-1:0];
        if (in_valid_i) begin
          if (in_item_i.operation == nat_pkg::OP_LOAD) begin
            mem_req_o.we = ({23'b0, in_item_i.slot} < 32'(nat_pkg::TABLE_DEPTH));
          end else if (in_item_i.operation == nat_pkg::OP_CLOSEST ||
                       in_item_i.operation == nat_pkg::OP_INTERSECT) begin
            if (used_count_i == '0) begin
              err_d   = nat_pkg::ST_EMPTY;
              state_d = S_ERR;
            end else if (in_item_i.operation == nat_pkg::OP_CLOSEST) begin
              sel_d   = SEL_NEAR;
              lo_d    = '0;
              hi_d    = used_count_i;
              t_d     = {in_item_i.query_azimuth, 1'b0};
              qaz_d   = in_item_i.query_azimuth;
              state_d = S_SRCH;
            end else begin
              lw_d    = $signed({3'b0, in_item_i.query_azimuth, 1'b0}) - $signed({2'b0, reach});
              hw_d    = $signed({3'b0, in_item_i.query_azimuth, 1'b0}) + $signed({2'b0, reach})
                        - 20'sd1;
              state_d = S_NORM;
            end
          end
        end
      end
      S_NORM: begin
        if (lw_q < 20'sd0) lw_d = lw_q + TURN2;
        else if (lw_q >= TURN2) lw_d = lw_q - TURN2;
        if (hw_q < 20'sd0) hw_d = hw_q + TURN2;
        else if (hw_q >= TURN2) hw_d = hw_q - TURN2;
        if (lw_ok && hw_ok) begin
          hwf_d   = hw_p1;
          wrap_d  = !(lw_q[16:0] < hw_p1);
          t_d     = lw_p1;
          sel_d   = SEL_BEGIN;
          lo_d    = '0;
          hi_d    = used_count_i;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        mem_req_o.addr = mid_c[AW-1:0];
        mid_d = mid_c;
        if (lo_q < hi_q) begin
          state_d = S_CMP;
        end else begin
          case (sel_q)
            SEL_NEAR: begin
              if (lo_q == used_count_i || lo_q == '0) begin
                a_d = n_m1[AW-1:0];
                b_d = '0;
              end else begin
                a_d = AW'(lo_q - CW'(1));
                b_d = lo_q[AW-1:0];
              end
              state_d = S_NEAR_A;
            end
            SEL_BEGIN: begin
              begin_d = lo_q;
              lo_d    = '0;
              hi_d    = used_count_i;
              t_d     = hwf_q;
              sel_d   = SEL_END;
            end
            default: begin
              if (cnt == '0) begin
                err_d   = nat_pkg::ST_NONE;
                state_d = S_ERR;
              end else begin
                trunc_d = (cnt > (CW + 1)'(nat_pkg::MAX_RUN));
                left_d  = trunc_d ? RW'(nat_pkg::MAX_RUN) : RW'(cnt);
                cur_d   = (wrap_q && begin_q == used_count_i) ? '0 : begin_q[AW-1:0];
                state_d = S_EMIT_RD;
              end
            end
          endcase
        end
      end
      S_CMP: begin
        if ({mem_rdata_i.angle, 1'b0} < t_q) lo_d = mid_q + CW'(1);
        else hi_d = mid_q;
        state_d = S_SRCH;
      end
      S_NEAR_A: begin
        mem_req_o.addr = a_q;
        state_d = S_NEAR_B;
      end
      S_NEAR_B: begin
        mem_req_o.addr = b_q;
        ent_a_d = mem_rdata_i;
        state_d = S_NEAR_L;
      end
      S_NEAR_L: begin
        ent_b_d = mem_rdata_i;
        state_d = S_PICK;
      end
      S_PICK: begin
        if (out_free_i) begin
          res_push_o = 1'b1;
          if (dist_a < dist_b) begin
            res_o.beam_index   = ent_a_q.beam;
            res_o.beam_azimuth = ent_a_q.azimuth;
          end else begin
            res_o.beam_index   = ent_b_q.beam;
            res_o.beam_azimuth = ent_b_q.azimuth;
          end
          res_o.last   = 1'b1;
          res_o.status = nat_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_PUT;
      end
      S_EMIT_PUT: begin
        if (out_free_i) begin
          res_push_o = 1'b1;
          res_o.beam_index   = mem_rdata_i.beam;
          res_o.beam_azimuth = mem_rdata_i.azimuth;
          res_o.last   = (left_q == RW'(1));
          res_o.status = (res_o.last && trunc_q) ? nat_pkg::ST_TRUNC : nat_pkg::ST_OK;
          left_d = left_q - RW'(1);
          cur_d  = (wrap_q && nxt == used_count_i) ? '0 : nxt[AW-1:0];
          state_d = res_o.last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_ERR: begin
        if (out_free_i) begin
          res_push_o   = 1'b1;
          res_o.last   = 1'b1;
          res_o.status = err_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;  lo_q <= lo_d;  hi_q <= hi_d;  mid_q <= mid_d;  begin_q <= begin_d;
    t_q <= t_d;  hwf_q <= hwf_d;  lw_q <= lw_d;  hw_q <= hw_d;  wrap_q <= wrap_d;
    trunc_q <= trunc_d;  a_q <= a_d;  b_q <= b_d;  cur_q <= cur_d;  left_q <= left_d;
    err_q <= err_d;  ent_a_q <= ent_a_d;  ent_b_q <= ent_b_d;  qaz_q <= qaz_d;
  end

endmodule

// File: rtl/nearest_azimuth_table_lookup_unit.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i/in_stall_o     in_item_i  (nat_pkg::in_item_t)
// out       output     out_valid_o/out_stall_i   out_item_o (nat_pkg::out_item_t)
// cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A load item writes the table as it is accepted. Each binary search step of a query is
// one table read and one compare.
// An intersecting query normalizes its window, runs two binary searches, and then
// reads and emits each item in turn.
// Reset clears only control state and the configuration registers; the table holds no reset value.
// A stall on the output holds the result register; the next item can be taken while it waits.
module nearest_azimuth_table_lookup_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nat_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nat_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic [9:0]                entry_count_q;
  logic [15:0]               beam_spacing_q;
  logic [nat_pkg::CNT_W-1:0] used_count;
  nat_pkg::mem_req_t         mem_req;
  nat_pkg::entry_t           mem_rdata;
  logic                      res_push, out_free;
  nat_pkg::out_item_t        res;
  logic                      out_valid_q;
  nat_pkg::out_item_t        out_q;

  // Counts beyond the table depth saturate to the full table.
  assign used_count = ({22'b0, entry_count_q} > 32'(nat_pkg::TABLE_DEPTH)) ?
                      nat_pkg::CNT_W'(nat_pkg::TABLE_DEPTH) :
                      nat_pkg::CNT_W'(entry_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q  <= '0;
      beam_spacing_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == nat_pkg::CFG_ENTRY_COUNT) entry_count_q <= cfg_data_i[9:0];
      else beam_spacing_q <= cfg_data_i;
    end
  end

  nat_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  nat_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_item_i      (in_item_i),
    .used_count_i   (used_count),
    .beam_spacing_i (beam_spacing_q),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .out_free_i     (out_free),
    .res_push_o     (res_push),
    .res_o          (res)
  );

  // The output register frees up in the same cycle its item is taken.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == nat_pkg::ST_EMPTY ||
                    out_item_o.status == nat_pkg::ST_NONE ||
                    out_item_o.status == nat_pkg::ST_TRUNC) |-> out_item_o.last)
    else $error("error or truncation status on an item that does not end its run");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.operation == nat_pkg::OP_LOAD |=> !in_stall_o)
    else $error("load item did not complete in one cycle");

  a_no_push_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> out_free)
    else $error("result pushed over an item still waiting");

endmodule
